### hw/rtl/spmd_pkg.sv
`default_nettype none
package spmd_pkg;

    localparam int COORD_BITS      = 21;
    localparam int COORD_FRAC_BITS = 10;
    localparam int POS_FRAC_BITS   = 16;

    localparam int FIELD_W = 63;
    localparam int IN_W    = 8 * FIELD_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DOT_W   = 48;
    localparam int PROD_W  = 2 * DOT_W;
    localparam int HALF_W  = DOT_W / 2;
    localparam int POS_W   = POS_FRAC_BITS + 1;
    localparam int THR_W   = 46;
    localparam int DIST_W  = 46;
    localparam int RATE_W  = 48;
    localparam int OUT_W   = DIST_W + RATE_W + 2 * POS_W;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

    localparam int STG_DIFF   = 1;
    localparam int STG_DOT    = 2;
    localparam int STG_PART   = 3;
    localparam int STG_PROD   = 4;
    localparam int STG_DEN    = 5;
    localparam int STG_SEL    = 6;
    localparam int STG_DIV0   = 7;
    localparam int STG_DIVN   = STG_DIV0 + POS_FRAC_BITS;
    localparam int STG_LANE   = STG_DIVN + 1;
    localparam int STG_LPART  = STG_LANE + 1;
    localparam int STG_LPROD  = STG_LPART + 1;
    localparam int STG_SUM    = STG_LPROD + 1;
    localparam int STG_OUT    = STG_SUM + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [2:0][DIFF_W-1:0] vec3_t;
    typedef logic signed [DOT_W-1:0] dot_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [1:0] {
        BR_GENERAL  = 2'd0,
        BR_DEG_A    = 2'd1,
        BR_DEG_B    = 2'd2,
        BR_PARALLEL = 2'd3
    } branch_t;

    typedef struct packed {
        vec3_t a;
        vec3_t b;
        vec3_t w;
        vec3_t va;
        vec3_t vb;
        vec3_t vw;
    } geom_t;

    typedef struct packed {
        dot_t aa;
        dot_t bb;
        dot_t ab;
        dot_t aw;
        dot_t bw;
    } dots_t;

    typedef struct packed {
        logic       deg_a;
        logic       deg_b;
        logic [1:0] best;
    } cls_t;

    function automatic coord_t coord_get(input logic [FIELD_W-1:0] packed_val,
                                         input logic [1:0] k);
        coord_t r;
        r = coord_t'(packed_val[k * COORD_BITS +: COORD_BITS]);
        return r;
    endfunction

    function automatic vec3_t vsub(input logic [FIELD_W-1:0] p,
                                   input logic [FIELD_W-1:0] q);
        vec3_t  r;
        coord_t cp;
        coord_t cq;
        for (int i = 0; i < 3; i++) begin
            cp = coord_get(p, 2'(i));
            cq = coord_get(q, 2'(i));
            r[i] = {cp[COORD_BITS-1], cp} - {cq[COORD_BITS-1], cq};
        end
        return r;
    endfunction

    function automatic dot_t dot3(input vec3_t u, input vec3_t v);
        dot_t r;
        dot_t ue;
        dot_t ve;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            ue = {{(DOT_W-DIFF_W){u[i][DIFF_W-1]}}, u[i]};
            ve = {{(DOT_W-DIFF_W){v[i][DIFF_W-1]}}, v[i]};
            r = r + ue * ve;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/spmd_mul.sv
`default_nettype none
module spmd_mul
    import spmd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic en_part,
    input  wire logic en_prod,
    input  wire dot_t x,
    input  wire dot_t y,
    output prod_t     p
);

    logic        [HALF_W-1:0]   xl, yl;
    logic signed [HALF_W-1:0]   xh, yh;
    logic        [DOT_W-1:0]    pll_reg;
    logic signed [DOT_W:0]      plh_reg, phl_reg;
    logic signed [DOT_W-1:0]    phh_reg;
    prod_t                      t_ll, t_mid, t_hh, p_next, p_reg;

    assign xl = x[HALF_W-1:0];
    assign yl = y[HALF_W-1:0];
    assign xh = x[DOT_W-1:HALF_W];
    assign yh = y[DOT_W-1:HALF_W];

    always_ff @(posedge aclk) begin
        if (en_part) begin
            pll_reg <= xl * yl;
            plh_reg <= $signed({1'b0, xl}) * yh;
            phl_reg <= xh * $signed({1'b0, yl});
            phh_reg <= xh * yh;
        end
    end

    always_comb begin
        t_ll   = {{(PROD_W-DOT_W){1'b0}}, pll_reg};
        t_mid  = {{(PROD_W-DOT_W-1){plh_reg[DOT_W]}}, plh_reg}
               + {{(PROD_W-DOT_W-1){phl_reg[DOT_W]}}, phl_reg};
        t_hh   = {{(PROD_W-DOT_W){phh_reg[DOT_W-1]}}, phh_reg};
        p_next = (t_hh <<< DOT_W) + (t_mid <<< HALF_W) + t_ll;
    end

    always_ff @(posedge aclk) begin
        if (en_prod) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

### hw/rtl/spmd_div.sv
`default_nettype none
module spmd_div
    import spmd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic [0:POS_FRAC_BITS] en,
    input  wire prod_t                  num,
    input  wire prod_t                  den,
    output logic [POS_W-1:0]            q
);

    logic [PROD_W:0]   rem_reg  [0:POS_FRAC_BITS];
    logic [PROD_W-1:0] den_reg  [0:POS_FRAC_BITS];
    logic [POS_W-1:0]  q_reg    [0:POS_FRAC_BITS];
    logic              done_reg [0:POS_FRAC_BITS];
    logic              num_pos, num_ge;

    assign num_pos = !num[PROD_W-1] && (num != '0);
    assign num_ge  = $unsigned(num) >= $unsigned(den);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= {1'b0, num};
            den_reg[0]  <= den;
            done_reg[0] <= !num_pos || num_ge;
            q_reg[0]    <= (num_pos && num_ge) ? POS_ONE : '0;
        end
    end

    for (genvar i = 1; i <= POS_FRAC_BITS; i++) begin : g_step
        logic [PROD_W:0] r2;
        logic            ge;
        assign r2 = {rem_reg[i-1][PROD_W-1:0], 1'b0};
        assign ge = r2 >= {1'b0, den_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en[i]) begin
                rem_reg[i]  <= ge ? r2 - {1'b0, den_reg[i-1]} : r2;
                den_reg[i]  <= den_reg[i-1];
                done_reg[i] <= done_reg[i-1];
                q_reg[i]    <= done_reg[i-1] ? q_reg[i-1]
                                             : {q_reg[i-1][POS_W-2:0], ge};
            end
        end
    end

    assign q = q_reg[POS_FRAC_BITS];

endmodule
`default_nettype wire

### hw/rtl/spmd_axis_lane.sv
`default_nettype none
module spmd_axis_lane
    import spmd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en_d,
    input  wire logic              en_part,
    input  wire logic              en_prod,
    input  wire logic [DIFF_W-1:0] a,
    input  wire logic [DIFF_W-1:0] b,
    input  wire logic [DIFF_W-1:0] w,
    input  wire logic [DIFF_W-1:0] va,
    input  wire logic [DIFF_W-1:0] vb,
    input  wire logic [DIFF_W-1:0] vw,
    input  wire logic [POS_W-1:0]  l1,
    input  wire logic [POS_W-1:0]  l2,
    output prod_t                  dd,
    output prod_t                  vdd
);

    dot_t ae, be, we, vae, vbe, vwe, l1e, l2e;
    dot_t d_next, vd_next, d_reg, vd_reg;

    always_comb begin
        ae  = {{(DOT_W-DIFF_W){a[DIFF_W-1]}}, a};
        be  = {{(DOT_W-DIFF_W){b[DIFF_W-1]}}, b};
        we  = {{(DOT_W-DIFF_W){w[DIFF_W-1]}}, w};
        vae = {{(DOT_W-DIFF_W){va[DIFF_W-1]}}, va};
        vbe = {{(DOT_W-DIFF_W){vb[DIFF_W-1]}}, vb};
        vwe = {{(DOT_W-DIFF_W){vw[DIFF_W-1]}}, vw};
        l1e = {{(DOT_W-POS_W){1'b0}}, l1};
        l2e = {{(DOT_W-POS_W){1'b0}}, l2};
        d_next  = (we <<< POS_FRAC_BITS) + ae * l1e - be * l2e;
        vd_next = (vwe <<< POS_FRAC_BITS) + vae * l1e - vbe * l2e;
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_reg  <= d_next;
            vd_reg <= vd_next;
        end
    end

    spmd_mul u_mul_dd (
        .aclk(aclk), .en_part(en_part), .en_prod(en_prod),
        .x(d_reg), .y(d_reg), .p(dd)
    );

    spmd_mul u_mul_vdd (
        .aclk(aclk), .en_part(en_part), .en_prod(en_prod),
        .x(vd_reg), .y(d_reg), .p(vdd)
    );

endmodule
`default_nettype wire

### hw/rtl/segment_pair_min_distance_core.sv
// Closest points between two moving 3D segments. Each input transaction
// carries both segments and their endpoint velocities; each output transaction
// returns the squared distance, its time derivative, the clamped positions on
// both segments and the branch taken. The block is a stallable pipeline of
// 28 register stages that takes one transaction per cycle unless the output
// stalls it; the positions come from the 17-stage restoring divider (a setup
// stage and sixteen quotient steps), and a bubble anywhere in the pipeline
// lets a new transaction in while the output waits.
// The degenerate threshold may only be written while no transaction is in
// flight.
`default_nettype none
module segment_pair_min_distance_core
    import spmd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // start_a, end_a, start_b, end_b, vel_start_a, vel_end_a, vel_start_b, vel_end_b
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // dist_sq, dist_sq_rate, pos_a, pos_b
    output logic [OUT_W-1:0]      m_tdata,
    // branch_taken
    output logic [1:0]            m_tuser,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [THR_W-1:0] cfg_data
);

    localparam int N = STG_OUT;

    logic [THR_W-1:0] thr_reg;
    logic [1:N]       v_reg;
    logic [1:N+1]     en;

    logic [FIELD_W-1:0] fld [0:7];

    geom_t            geom_reg [STG_DIFF:STG_DIVN];
    vec3_t            pair_reg [0:3];
    dot_t             pdd_reg  [0:3];
    dots_t            dots_reg [STG_DOT:STG_DEN];
    cls_t             cls_reg  [STG_PART:STG_DEN];
    prod_t            den_reg, numa_reg, numb_reg;
    prod_t            p_aabb, p_abab, p_abbw, p_bbaw, p_aabw, p_abaw;
    branch_t          br_reg   [STG_SEL:STG_SUM];
    prod_t            n1_reg, d1_reg, n2_reg, d2_reg;
    logic [POS_W-1:0] l1, l2;
    logic [POS_W-1:0] l1_reg   [STG_LANE:STG_SUM];
    logic [POS_W-1:0] l2_reg   [STG_LANE:STG_SUM];
    prod_t            lane_dd  [0:2];
    prod_t            lane_vdd [0:2];
    prod_t            sq_reg, rt_reg;

    logic [DIST_W-1:0] dist_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [POS_W-1:0]  pa_out_reg, pb_out_reg;
    branch_t           br_out_reg;

    for (genvar k = 0; k < 8; k++) begin : g_fld
        assign fld[k] = s_tdata[k * FIELD_W +: FIELD_W];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(1);
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    assign en[N+1] = m_tready;
    for (genvar k = 1; k <= N; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign s_tready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= N; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[STG_DIFF]) begin
            geom_reg[STG_DIFF].a  <= vsub(fld[1], fld[0]);
            geom_reg[STG_DIFF].b  <= vsub(fld[3], fld[2]);
            geom_reg[STG_DIFF].w  <= vsub(fld[0], fld[2]);
            geom_reg[STG_DIFF].va <= vsub(fld[5], fld[4]);
            geom_reg[STG_DIFF].vb <= vsub(fld[7], fld[6]);
            geom_reg[STG_DIFF].vw <= vsub(fld[4], fld[6]);
            pair_reg[0] <= vsub(fld[2], fld[0]);
            pair_reg[1] <= vsub(fld[3], fld[0]);
            pair_reg[2] <= vsub(fld[2], fld[1]);
            pair_reg[3] <= vsub(fld[3], fld[1]);
        end
        for (int k = STG_DIFF + 1; k <= STG_DIVN; k++) begin
            if (en[k]) begin
                geom_reg[k] <= geom_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[STG_DOT]) begin
            dots_reg[STG_DOT].aa <= dot3(geom_reg[STG_DIFF].a, geom_reg[STG_DIFF].a);
            dots_reg[STG_DOT].bb <= dot3(geom_reg[STG_DIFF].b, geom_reg[STG_DIFF].b);
            dots_reg[STG_DOT].ab <= dot3(geom_reg[STG_DIFF].a, geom_reg[STG_DIFF].b);
            dots_reg[STG_DOT].aw <= dot3(geom_reg[STG_DIFF].a, geom_reg[STG_DIFF].w);
            dots_reg[STG_DOT].bw <= dot3(geom_reg[STG_DIFF].b, geom_reg[STG_DIFF].w);
            for (int c = 0; c < 4; c++) begin
                pdd_reg[c] <= dot3(pair_reg[c], pair_reg[c]);
            end
        end
        for (int k = STG_DOT + 1; k <= STG_DEN; k++) begin
            if (en[k]) begin
                dots_reg[k] <= dots_reg[k-1];
            end
        end
    end

    logic [1:0] best_lo, best_hi, best;
    dot_t       min_lo, min_hi;
    cls_t       cls_next;

    always_comb begin
        best_lo = (pdd_reg[1] < pdd_reg[0]) ? 2'd1 : 2'd0;
        min_lo  = (pdd_reg[1] < pdd_reg[0]) ? pdd_reg[1] : pdd_reg[0];
        best_hi = (pdd_reg[3] < pdd_reg[2]) ? 2'd3 : 2'd2;
        min_hi  = (pdd_reg[3] < pdd_reg[2]) ? pdd_reg[3] : pdd_reg[2];
        best    = (min_hi < min_lo) ? best_hi : best_lo;
        cls_next.best  = best;
        cls_next.deg_a = $unsigned(dots_reg[STG_DOT].aa) < {2'b0, thr_reg};
        cls_next.deg_b = $unsigned(dots_reg[STG_DOT].bb) < {2'b0, thr_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[STG_PART]) begin
            cls_reg[STG_PART] <= cls_next;
        end
        for (int k = STG_PART + 1; k <= STG_DEN; k++) begin
            if (en[k]) begin
                cls_reg[k] <= cls_reg[k-1];
            end
        end
    end

    spmd_mul u_mul_aabb (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].aa), .y(dots_reg[STG_DOT].bb), .p(p_aabb));
    spmd_mul u_mul_abab (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].ab), .y(dots_reg[STG_DOT].ab), .p(p_abab));
    spmd_mul u_mul_abbw (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].ab), .y(dots_reg[STG_DOT].bw), .p(p_abbw));
    spmd_mul u_mul_bbaw (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].bb), .y(dots_reg[STG_DOT].aw), .p(p_bbaw));
    spmd_mul u_mul_aabw (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].aa), .y(dots_reg[STG_DOT].bw), .p(p_aabw));
    spmd_mul u_mul_abaw (.aclk(aclk), .en_part(en[STG_PART]), .en_prod(en[STG_PROD]),
        .x(dots_reg[STG_DOT].ab), .y(dots_reg[STG_DOT].aw), .p(p_abaw));

    always_ff @(posedge aclk) begin
        if (en[STG_DEN]) begin
            den_reg  <= p_aabb - p_abab;
            numa_reg <= p_abbw - p_bbaw;
            numb_reg <= p_aabw - p_abaw;
        end
    end

    prod_t   zero_w, one_w, aa_w, bb_w, aw_w, bw_w;
    prod_t   n1_next, d1_next, n2_next, d2_next;
    branch_t br_next;
    logic    par;
    cls_t    cl;

    always_comb begin
        cl     = cls_reg[STG_DEN];
        zero_w = '0;
        one_w  = PROD_W'(1);
        aa_w   = {{(PROD_W-DOT_W){dots_reg[STG_DEN].aa[DOT_W-1]}}, dots_reg[STG_DEN].aa};
        bb_w   = {{(PROD_W-DOT_W){dots_reg[STG_DEN].bb[DOT_W-1]}}, dots_reg[STG_DEN].bb};
        aw_w   = {{(PROD_W-DOT_W){dots_reg[STG_DEN].aw[DOT_W-1]}}, dots_reg[STG_DEN].aw};
        bw_w   = {{(PROD_W-DOT_W){dots_reg[STG_DEN].bw[DOT_W-1]}}, dots_reg[STG_DEN].bw};
        par    = {den_reg, 2'b00}
               < {{(PROD_W+2-THR_W-2*COORD_FRAC_BITS){1'b0}}, thr_reg,
                  {(2*COORD_FRAC_BITS){1'b0}}};
        if (cl.deg_a) begin
            br_next = BR_DEG_A;
            n1_next = zero_w;
            d1_next = one_w;
            n2_next = cl.deg_b ? zero_w : bw_w;
            d2_next = cl.deg_b ? one_w : bb_w;
        end else if (cl.deg_b) begin
            br_next = BR_DEG_B;
            n1_next = -aw_w;
            d1_next = aa_w;
            n2_next = zero_w;
            d2_next = one_w;
        end else if (par) begin
            br_next = BR_PARALLEL;
            n1_next = cl.best[1] ? one_w : zero_w;
            d1_next = one_w;
            n2_next = cl.best[0] ? one_w : zero_w;
            d2_next = one_w;
        end else begin
            br_next = BR_GENERAL;
            n1_next = numa_reg;
            d1_next = den_reg;
            n2_next = numb_reg;
            d2_next = den_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[STG_SEL]) begin
            br_reg[STG_SEL] <= br_next;
            n1_reg <= n1_next;
            d1_reg <= d1_next;
            n2_reg <= n2_next;
            d2_reg <= d2_next;
        end
        for (int k = STG_SEL + 1; k <= STG_SUM; k++) begin
            if (en[k]) begin
                br_reg[k] <= br_reg[k-1];
            end
        end
    end

    spmd_div u_div_a (.aclk(aclk), .en(en[STG_DIV0:STG_DIVN]),
        .num(n1_reg), .den(d1_reg), .q(l1));
    spmd_div u_div_b (.aclk(aclk), .en(en[STG_DIV0:STG_DIVN]),
        .num(n2_reg), .den(d2_reg), .q(l2));

    always_ff @(posedge aclk) begin
        if (en[STG_LANE]) begin
            l1_reg[STG_LANE] <= l1;
            l2_reg[STG_LANE] <= l2;
        end
        for (int k = STG_LANE + 1; k <= STG_SUM; k++) begin
            if (en[k]) begin
                l1_reg[k] <= l1_reg[k-1];
                l2_reg[k] <= l2_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        spmd_axis_lane u_lane (
            .aclk(aclk),
            .en_d(en[STG_LANE]), .en_part(en[STG_LPART]), .en_prod(en[STG_LPROD]),
            .a(geom_reg[STG_DIVN].a[i]),   .b(geom_reg[STG_DIVN].b[i]),
            .w(geom_reg[STG_DIVN].w[i]),   .va(geom_reg[STG_DIVN].va[i]),
            .vb(geom_reg[STG_DIVN].vb[i]), .vw(geom_reg[STG_DIVN].vw[i]),
            .l1(l1), .l2(l2),
            .dd(lane_dd[i]), .vdd(lane_vdd[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[STG_SUM]) begin
            sq_reg <= lane_dd[0] + lane_dd[1] + lane_dd[2];
            rt_reg <= (lane_vdd[0] + lane_vdd[1] + lane_vdd[2]) <<< 1;
        end
    end

    localparam logic [PROD_W-2*POS_FRAC_BITS-1:0] DIST_MAX =
        {{(PROD_W-2*POS_FRAC_BITS-DIST_W){1'b0}}, {DIST_W{1'b1}}};
    localparam logic [PROD_W-2*POS_FRAC_BITS-1:0] RATE_POS_MAX =
        {{(PROD_W-2*POS_FRAC_BITS-RATE_W+1){1'b0}}, {(RATE_W-1){1'b1}}};
    localparam logic [PROD_W-2*POS_FRAC_BITS-1:0] RATE_NEG_MAX = RATE_POS_MAX + 1'b1;

    logic [PROD_W-2*POS_FRAC_BITS-1:0] sq_sh, mag_sh, cap;
    prod_t                             mag;
    logic                              neg;
    logic [DIST_W-1:0]                 dist_next;
    logic [RATE_W-1:0]                 mv, rate_next;

    always_comb begin
        sq_sh     = sq_reg[PROD_W-1:2*POS_FRAC_BITS];
        dist_next = (sq_sh > DIST_MAX) ? {DIST_W{1'b1}} : sq_sh[DIST_W-1:0];
        neg       = rt_reg[PROD_W-1];
        mag       = neg ? -rt_reg : rt_reg;
        mag_sh    = mag[PROD_W-1:2*POS_FRAC_BITS];
        cap       = neg ? RATE_NEG_MAX : RATE_POS_MAX;
        mv        = (mag_sh > cap) ? cap[RATE_W-1:0] : mag_sh[RATE_W-1:0];
        rate_next = neg ? -mv : mv;
    end

    always_ff @(posedge aclk) begin
        if (en[STG_OUT]) begin
            dist_reg   <= dist_next;
            rate_reg   <= rate_next;
            pa_out_reg <= l1_reg[STG_SUM];
            pb_out_reg <= l2_reg[STG_SUM];
            br_out_reg <= br_reg[STG_SUM];
        end
    end

    assign m_tvalid = v_reg[N];
    assign m_tdata  = {pb_out_reg, pa_out_reg, rate_reg, dist_reg};
    assign m_tuser  = br_out_reg;

endmodule
`default_nettype wire

### hw/rtl/spmd_checker.sv
`default_nettype none
module spmd_checker
    import spmd_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic [IN_W-1:0]  s_tdata,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [THR_W-1:0] cfg_data
);

    logic [POS_W-1:0] pos_a, pos_b;

    assign pos_a = m_tdata[DIST_W+RATE_W +: POS_W];
    assign pos_b = m_tdata[DIST_W+RATE_W+POS_W +: POS_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output transaction changed.");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pos_a <= POS_ONE && pos_b <= POS_ONE)
        else $error("Position beyond one.");

    a_deg_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BR_DEG_A |-> pos_a == '0)
        else $error("Degenerate first segment with nonzero position.");

    a_deg_b: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BR_DEG_B |-> pos_b == '0)
        else $error("Degenerate second segment with nonzero position.");

    a_parallel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BR_PARALLEL |->
            (pos_a == '0 || pos_a == POS_ONE) && (pos_b == '0 || pos_b == POS_ONE))
        else $error("Parallel case returned an interior position.");

endmodule

bind segment_pair_min_distance_core spmd_checker u_spmd_checker (.*);
`default_nettype wire

### verif/segment_pair_min_distance_core_tb.sv
`default_nettype none
module segment_pair_min_distance_core_tb;
    import spmd_pkg::*;

    typedef logic signed [127:0] acc_t;
    typedef logic [FIELD_W-1:0] field_t;

    typedef struct {
        field_t pt [8];
    } pair_item_t;

    typedef struct {
        logic [DIST_W-1:0] dist_sq;
        logic [RATE_W-1:0] rate;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        branch_t           branch;
    } distance_t;

    localparam longint POS_UNIT = longint'(1) << POS_FRAC_BITS;

    class distance_scoreboard;
        distance_t         expected_q[$];
        logic [THR_W-1:0]  threshold;
        int                mismatches;

        function new();
            threshold  = 1;
            mismatches = 0;
        endfunction

        function automatic longint coord_at(field_t f, int k);
            logic signed [COORD_BITS-1:0] c;
            c = f[k*COORD_BITS +: COORD_BITS];
            return longint'(c);
        endfunction

        function automatic longint dot3l(longint u[3], longint v[3]);
            return u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        endfunction

        function automatic logic [POS_W-1:0] clamp_quotient(acc_t num, acc_t den);
            logic [POS_W-1:0] q;
            q = '0;
            if (num <= 0) return '0;
            if (num >= den) return POS_ONE;
            for (int i = 0; i < POS_FRAC_BITS; i++) begin
                num = num <<< 1;
                q = q << 1;
                if (num >= den) begin
                    num = num - den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function automatic distance_t closest_points(pair_item_t it);
            distance_t r;
            longint p[8][3];
            longint a[3], b[3], w[3], va[3], vb[3], vw[3], e[3];
            longint aa, bb, ab, aw, bw, best, dd, d, vd;
            acc_t   den, sq, rt, mag, lim;
            logic [POS_W-1:0] l1, l2;
            int bi;
            logic neg;
            for (int k = 0; k < 8; k++)
                for (int i = 0; i < 3; i++)
                    p[k][i] = coord_at(it.pt[k], i);
            for (int i = 0; i < 3; i++) begin
                a[i]  = p[1][i] - p[0][i];
                b[i]  = p[3][i] - p[2][i];
                w[i]  = p[0][i] - p[2][i];
                va[i] = p[5][i] - p[4][i];
                vb[i] = p[7][i] - p[6][i];
                vw[i] = p[4][i] - p[6][i];
            end
            aa = dot3l(a, a); bb = dot3l(b, b); ab = dot3l(a, b);
            aw = dot3l(a, w); bw = dot3l(b, w);
            l1 = '0;
            l2 = '0;
            if (aa < longint'(threshold)) begin
                r.branch = BR_DEG_A;
                if (bb >= longint'(threshold))
                    l2 = clamp_quotient(acc_t'(bw), acc_t'(bb));
            end else if (bb < longint'(threshold)) begin
                r.branch = BR_DEG_B;
                l1 = clamp_quotient(acc_t'(-aw), acc_t'(aa));
            end else begin
                den = acc_t'(aa) * acc_t'(bb) - acc_t'(ab) * acc_t'(ab);
                lim = acc_t'(threshold) <<< (2 * COORD_FRAC_BITS);
                if ((den <<< 2) < lim) begin
                    r.branch = BR_PARALLEL;
                    best = -1;
                    bi = 0;
                    for (int c = 0; c < 4; c++) begin
                        for (int i = 0; i < 3; i++)
                            e[i] = p[(c & 1) ? 3 : 2][i] - p[(c >> 1) ? 1 : 0][i];
                        dd = dot3l(e, e);
                        if (best < 0 || dd < best) begin
                            best = dd;
                            bi = c;
                        end
                    end
                    l1 = (bi >> 1) ? POS_ONE : '0;
                    l2 = (bi & 1) ? POS_ONE : '0;
                end else begin
                    r.branch = BR_GENERAL;
                    l1 = clamp_quotient(acc_t'(ab) * acc_t'(bw) - acc_t'(bb) * acc_t'(aw), den);
                    l2 = clamp_quotient(acc_t'(aa) * acc_t'(bw) - acc_t'(ab) * acc_t'(aw), den);
                end
            end
            sq = '0;
            rt = '0;
            for (int i = 0; i < 3; i++) begin
                d  = w[i] * POS_UNIT + a[i] * longint'(l1) - b[i] * longint'(l2);
                vd = vw[i] * POS_UNIT + va[i] * longint'(l1) - vb[i] * longint'(l2);
                sq = sq + acc_t'(d) * acc_t'(d);
                rt = rt + acc_t'(vd) * acc_t'(d);
            end
            rt = rt <<< 1;
            sq = sq >>> (2 * POS_FRAC_BITS);
            r.dist_sq = (sq > acc_t'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : sq[DIST_W-1:0];
            neg = rt < 0;
            mag = neg ? -rt : rt;
            mag = mag >>> (2 * POS_FRAC_BITS);
            if (neg) begin
                if (mag > (acc_t'(1) <<< (RATE_W - 1))) mag = acc_t'(1) <<< (RATE_W - 1);
                mag = -mag;
            end else if (mag > (acc_t'(1) <<< (RATE_W - 1)) - 1) begin
                mag = (acc_t'(1) <<< (RATE_W - 1)) - 1;
            end
            r.rate  = mag[RATE_W-1:0];
            r.pos_a = l1;
            r.pos_b = l2;
            return r;
        endfunction

        function void note_input(pair_item_t it);
            expected_q.push_back(closest_points(it));
        endfunction

        function void check_result(distance_t got);
            distance_t exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result dist=%0h rate=%0h pa=%0h pb=%0h br=%0d",
                             got.dist_sq, got.rate, got.pos_a, got.pos_b, got.branch);
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.dist_sq !== got.dist_sq || exp_r.rate !== got.rate ||
                exp_r.pos_a !== got.pos_a || exp_r.pos_b !== got.pos_b ||
                exp_r.branch !== got.branch) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected dist=%0h rate=%0h pa=%0h pb=%0h br=%0d, ",
                              "got dist=%0h rate=%0h pa=%0h pb=%0h br=%0d"},
                             exp_r.dist_sq, exp_r.rate, exp_r.pos_a, exp_r.pos_b,
                             exp_r.branch, got.dist_sq, got.rate, got.pos_a, got.pos_b,
                             got.branch);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    distance_scoreboard sb;
    int idle_cycles;
    int burst_left;
    int items_sent;

    segment_pair_min_distance_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint rand_coord(int k);
        return longint'($urandom_range(0, (32'd1 << (k + 1)) - 1)) - (longint'(1) << k);
    endfunction

    function automatic field_t pack3(longint x, longint y, longint z);
        return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic field_t rand_point(int k);
        return pack3(rand_coord(k), rand_coord(k), rand_coord(k));
    endfunction

    function automatic field_t rand_field();
        return field_t'({$urandom(), $urandom()});
    endfunction

    function automatic field_t offset_point(field_t base, longint dx, longint dy, longint dz);
        longint c[3];
        for (int i = 0; i < 3; i++) begin
            logic signed [COORD_BITS-1:0] v;
            v = base[i*COORD_BITS +: COORD_BITS];
            c[i] = longint'(v);
        end
        return pack3(c[0] + dx, c[1] + dy, c[2] + dz);
    endfunction

    function automatic pair_item_t make_pair(int mode);
        pair_item_t it;
        longint dx, dy, dz, m;
        int k;
        k = $urandom_range(1, 20);
        for (int i = 0; i < 8; i++) it.pt[i] = rand_point(k);
        for (int i = 4; i < 8; i++) it.pt[i] = rand_point($urandom_range(1, 20));
        case (mode)
            0: begin
                for (int i = 0; i < 8; i++) it.pt[i] = rand_field();
            end
            2: begin
                it.pt[0] = rand_point(18);
                it.pt[1] = offset_point(it.pt[0], rand_coord(1), 0, 0);
            end
            3: begin
                it.pt[2] = rand_point(18);
                it.pt[3] = offset_point(it.pt[2], 0, rand_coord(1), 0);
            end
            4: begin
                dx = rand_coord(9); dy = rand_coord(9); dz = rand_coord(9);
                m = longint'($urandom_range(1, 3)) * (($urandom_range(0, 1) != 0) ? -1 : 1);
                it.pt[0] = rand_point(18);
                it.pt[1] = offset_point(it.pt[0], dx, dy, dz);
                it.pt[2] = rand_point(18);
                it.pt[3] = offset_point(it.pt[2], m * dx, m * dy, m * dz);
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_pair(pair_item_t it);
        int gap;
        for (int i = 0; i < 8; i++) s_tdata[i*FIELD_W +: FIELD_W] <= it.pt[i];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.threshold = value;
    endtask

    task automatic send_directed();
        pair_item_t it;
        field_t pmax, pmin, zero;
        pmax = pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        pmin = pack3(-(longint'(1) << 20), -(longint'(1) << 20), -(longint'(1) << 20));
        zero = '0;
        for (int i = 0; i < 8; i++) it.pt[i] = zero;
        send_pair(it);
        it.pt[0] = pmin; it.pt[1] = pmax; it.pt[2] = pmax; it.pt[3] = pmin;
        it.pt[4] = pmax; it.pt[5] = pmin; it.pt[6] = pmin; it.pt[7] = pmax;
        send_pair(it);
        it.pt[0] = pmax; it.pt[1] = pmax; it.pt[2] = pmin; it.pt[3] = pmin;
        it.pt[4] = pmax; it.pt[5] = pmax; it.pt[6] = pmin; it.pt[7] = pmin;
        send_pair(it);
        it.pt[4] = pmin; it.pt[5] = pmin; it.pt[6] = pmax; it.pt[7] = pmax;
        send_pair(it);
        for (int i = 0; i < 8; i++) it.pt[i] = {FIELD_W{1'b1}};
        send_pair(it);
        // Parallel segments of equal length, offset sideways: two endpoint pairs tie.
        it.pt[0] = pack3(0, 0, 0);   it.pt[1] = pack3(1024, 0, 0);
        it.pt[2] = pack3(0, 512, 0); it.pt[3] = pack3(1024, 512, 0);
        send_pair(it);
        it.pt[2] = pack3(1024, 512, 0); it.pt[3] = pack3(0, 512, 0);
        send_pair(it);
        it.pt[2] = pack3(4096, 512, 0); it.pt[3] = pack3(2048, 512, 0);
        send_pair(it);
        // Crossing segments, then two pairs whose closest points lie past the ends.
        it.pt[0] = pack3(-1024, 0, 0); it.pt[1] = pack3(1024, 0, 0);
        it.pt[2] = pack3(0, -1024, 256); it.pt[3] = pack3(0, 1024, 256);
        send_pair(it);
        it.pt[2] = pack3(4096, 1024, 256); it.pt[3] = pack3(4096, 3072, 256);
        send_pair(it);
        it.pt[2] = pack3(-4096, -3072, 0); it.pt[3] = pack3(-4096, -1024, 0);
        send_pair(it);
        // One segment collapsed to a point, on either side and both.
        it.pt[1] = it.pt[0];
        send_pair(it);
        it.pt[0] = pack3(-1024, 0, 0); it.pt[1] = pack3(1024, 0, 0);
        it.pt[3] = it.pt[2];
        send_pair(it);
        it.pt[2] = pack3(0, 300, 0); it.pt[3] = it.pt[2];
        send_pair(it);
        it.pt[2] = pack3(5000, 300, 0); it.pt[3] = it.pt[2];
        send_pair(it);
        it.pt[1] = it.pt[0];
        send_pair(it);
        for (int m = 0; m < 5; m++) send_pair(make_pair(m));
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                s_tvalid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge aclk);
            end
            send_pair(make_pair($urandom_range(0, 5)));
        end
    endtask

    initial begin
        int rx_cycle;
        int rx_mode;
        rx_cycle = 0;
        rx_mode  = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (m_tvalid && m_tready)
                sb.check_result('{m_tdata[DIST_W-1:0],
                                  m_tdata[DIST_W +: RATE_W],
                                  m_tdata[DIST_W+RATE_W +: POS_W],
                                  m_tdata[DIST_W+RATE_W+POS_W +: POS_W],
                                  branch_t'(m_tuser)});
            if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 3);
            if (rx_cycle >= 2000 && rx_cycle < 2400)
                m_tready <= 1'b0;
            else
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) != 0);
                    2: m_tready <= (rx_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sb          = new();
        burst_left  = 0;
        items_sent  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        send_random(600);
        write_threshold('0);
        send_directed();
        send_random(400);
        write_threshold({THR_W{1'b1}});
        send_random(200);
        write_threshold(THR_W'({$urandom(), $urandom()}) >> $urandom_range(0, 40));
        send_random(400);
        write_threshold(THR_W'(1));
        send_random(300);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
